>>> src/sfd_pkg.sv
// shared types, constants and helpers for the stereo feedback delay
package sfd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_W      = 16;
    localparam int FB_FIELD_W  = 15;
    localparam int CNT_W       = 16;
    localparam int SHIFT_W     = 4;
    localparam int SAT_W       = 48;
    localparam int Q_SHIFT     = 15;

    localparam logic [GAIN_W-1:0]  FB_MAX      = 16'd31129;
    localparam logic [GAIN_W-1:0]  MIX_ONE     = 16'd32768;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd11;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_DELAY    = 3'd1,
        REG_FEEDBACK = 3'd2,
        REG_MIX      = 3'd3,
        REG_SHIFT    = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
        logic                          right_present;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } t_out_item;

    // classified item between front and back
    typedef struct packed {
        logic                          bypass;
        logic                          stereo;
        logic signed [SAMPLE_BITS-1:0] dry_left;
        logic signed [SAMPLE_BITS-1:0] dry_right;
    } t_queue_item;

    // per-cycle strobes from the sequencer to both lanes
    typedef struct packed {
        logic rd;
        logic cap_a;
        logic interp;
        logic wet;
        logic mul_fb;
        logic wr;
        logic mul_mix;
    } t_lane_ctl;

    // clamp to signed sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = (SAT_W'(1) <<< (SAMPLE_BITS - 1)) - SAT_W'(1);
        lo = -hi - SAT_W'(1);
        if (v > hi) begin
            sat_sample = hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            sat_sample = lo[SAMPLE_BITS-1:0];
        end else begin
            sat_sample = v[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

>>> src/stereo_feedback_delay.sv
// top level of the stereo feedback delay
//
// channel | direction | handshake            | payload
// in      | input     | i_in_valid/o_in_stall   | i_in  (t_in_item)
// out     | output    | o_out_valid/i_out_stall | o_out (t_out_item)
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// an echo item passes the back-end sequencer: two reads on the single read
// port of each delay memory, then interpolation, wet sum, and the feedback,
// dry and mix multiplies; a bypassed item goes to the output register.
// a two-entry queue decouples input from work. after reset the delay memories
// are cleared one address a cycle with input stalled; cfg writes always taken.
module stereo_feedback_delay import sfd_pkg::*; #(
    parameter int ADDR_BITS = 17,
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                           enable;
    logic                           clearing;
    logic                           advance;
    logic                           q_valid;
    logic                           q_pop;
    t_queue_item                    q_item;
    logic [ADDR_BITS+FRAC_BITS-1:0] delay;
    logic [GAIN_W-1:0]              feedback;
    logic [GAIN_W-1:0]              mix;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    sfd_ctrl #(.ADDR_BITS(ADDR_BITS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (advance),
        .o_enable    (enable),
        .o_delay     (delay),
        .o_feedback  (feedback),
        .o_mix       (mix)
    );

    sfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_enable   (enable),
        .i_clearing (clearing),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    sfd_back #(.ADDR_BITS(ADDR_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_advance   (advance),
        .i_delay     (delay),
        .i_feedback  (feedback),
        .i_mix       (mix),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> src/sfd_front.sv
// front end: accepts items, classifies them and queues them for the back end
module sfd_front import sfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    input  logic        i_enable,
    input  logic        i_clearing,
    output logic        o_q_valid,
    output t_queue_item o_q_item,
    input  logic        i_q_pop
);

    t_queue_item r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    t_queue_item item;

    assign o_in_stall = (r_count == 2'd2) || i_clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    // classify: bypass when disabled, mono feeds left into the right lane
    always_comb begin
        item.bypass   = !i_enable;
        item.stereo   = i_in.right_present;
        item.dry_left = i_in.sample_left;
        if (i_in.right_present) begin
            item.dry_right = i_in.sample_right;
        end else if (i_enable) begin
            item.dry_right = i_in.sample_left;
        end else begin
            item.dry_right = '0;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != 2'd0)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue overflow");

endmodule

>>> src/sfd_ctrl.sv
// configuration registers and linear parameter ramps
module sfd_ctrl import sfd_pkg::*; #(
    parameter int ADDR_BITS = 17,
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                           i_advance,
    output logic                           o_enable,
    output logic [ADDR_BITS+FRAC_BITS-1:0] o_delay,
    output logic [GAIN_W-1:0]              o_feedback,
    output logic [GAIN_W-1:0]              o_mix
);

    localparam int DW = ADDR_BITS + FRAC_BITS;
    localparam int RW = (DW > GAIN_W) ? DW : GAIN_W;

    logic               r_enable;
    logic [SHIFT_W-1:0] r_shift;
    logic [RW-1:0]      r_cur  [3];
    logic [RW-1:0]      r_tgt  [3];
    logic signed [RW:0] r_step [3];
    logic [CNT_W-1:0]   r_cnt  [3];

    logic [RW-1:0]      new_val [3];
    logic [2:0]         slot_we;
    logic signed [RW:0] diff    [3];
    logic [RW:0]        mag     [3];
    logic signed [RW:0] step    [3];
    logic [FB_FIELD_W-1:0] fb_raw;
    logic [GAIN_W-1:0]  mix_raw;

    assign fb_raw  = i_cfg_data[FB_FIELD_W-1:0];
    assign mix_raw = i_cfg_data[GAIN_W-1:0];

    // decode the write and clamp gains
    always_comb begin
        slot_we    = 3'b000;
        new_val[0] = RW'(i_cfg_data[DW-1:0]);
        new_val[1] = ({1'b0, fb_raw} > FB_MAX) ? RW'(FB_MAX) : RW'(fb_raw);
        new_val[2] = (mix_raw > MIX_ONE) ? RW'(MIX_ONE) : RW'(mix_raw);
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_DELAY:    slot_we = 3'b001;
                REG_FEEDBACK: slot_we = 3'b010;
                REG_MIX:      slot_we = 3'b100;
                default:      slot_we = 3'b000;
            endcase
        end
    end

    // ramp step, truncated toward zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = $signed({1'b0, new_val[k]}) - $signed({1'b0, r_cur[k]});
            mag[k]  = diff[k][RW] ? (RW+1)'(0) - diff[k] : diff[k];
            mag[k]  = mag[k] >> r_shift;
            step[k] = diff[k][RW] ? -$signed(mag[k]) : $signed(mag[k]);
        end
    end

    // plain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_shift  <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            if (t_cfg_reg'(i_cfg_index) == REG_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end
            if (t_cfg_reg'(i_cfg_index) == REG_SHIFT) begin
                r_shift <= i_cfg_data[SHIFT_W-1:0];
            end
        end
    end

    // ramp slots: start on a changed target, advance once per echo item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cur[k]  <= '0;
                r_tgt[k]  <= '0;
                r_step[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (slot_we[k] && new_val[k] != r_tgt[k]) begin
                    r_tgt[k]  <= new_val[k];
                    r_cnt[k]  <= CNT_W'(1) << r_shift;
                    r_step[k] <= step[k];
                end else if (i_advance) begin
                    if (r_cnt[k] == '0) begin
                        r_cur[k] <= r_tgt[k];
                    end else begin
                        r_cnt[k] <= r_cnt[k] - CNT_W'(1);
                        if (r_cnt[k] == CNT_W'(1)) begin
                            r_cur[k] <= r_tgt[k];
                        end else begin
                            r_cur[k] <= RW'($signed({1'b0, r_cur[k]}) + r_step[k]);
                        end
                    end
                end
            end
        end
    end

    assign o_enable   = r_enable;
    assign o_delay    = r_cur[0][DW-1:0];
    assign o_feedback = r_cur[1][GAIN_W-1:0];
    assign o_mix      = r_cur[2][GAIN_W-1:0];

endmodule

>>> src/sfd_lane.sv
// one channel: delay memory plus interpolation, feedback and crossfade datapath
module sfd_lane import sfd_pkg::*; #(
    parameter int ADDR_BITS = 17,
    parameter int FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  t_lane_ctl                            i_ctl,
    input  logic                                 i_clr,
    input  logic [ADDR_BITS-1:0]                 i_raddr,
    input  logic [ADDR_BITS-1:0]                 i_waddr,
    input  logic signed [SAMPLE_BITS-1:0]        i_dry,
    input  logic [((FRAC_BITS > 0) ? FRAC_BITS : 1)-1:0] i_frac,
    input  logic [GAIN_W-1:0]                    i_fb,
    input  logic [GAIN_W-1:0]                    i_mix,
    output logic signed [SAMPLE_BITS-1:0]        o_result
);

    localparam int SW    = SAMPLE_BITS;
    localparam int FW    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int DEPTH = 1 << ADDR_BITS;

    logic signed [SW-1:0] mem [DEPTH];
    logic signed [SW-1:0] r_rd;
    logic signed [SW-1:0] r_a;
    logic signed [SW+FW+1:0] r_dprod;
    logic signed [SW-1:0] r_wet;
    logic signed [SW+16:0] r_pfb;
    logic signed [SW+17:0] r_pm1;
    logic signed [SW+17:0] r_pm2;

    logic signed [SW:0]      diff;
    logic signed [SW+FW+1:0] a_ext;
    logic signed [SW+FW+1:0] wet_sum;
    logic signed [SW+16:0]   dry_fb;
    logic signed [SW+16:0]   fb_sum;
    logic signed [SAT_W-1:0] fb_wide;
    logic signed [SW-1:0]    wdata;
    logic [GAIN_W:0]         dry_gain;
    logic signed [SW+18:0]   o_sum;
    logic signed [SAT_W-1:0] o_wide;

    // interpolation between the two taps
    assign diff    = {r_rd[SW-1], r_rd} - {r_a[SW-1], r_a};
    assign a_ext   = (SW+FW+2)'(r_a);
    assign wet_sum = a_ext + (r_dprod >>> FRAC_BITS);

    // feedback write value
    assign dry_fb  = (SW+17)'(i_dry);
    assign fb_sum  = dry_fb + (r_pfb >>> Q_SHIFT);
    assign fb_wide = SAT_W'(fb_sum);
    assign wdata   = i_clr ? '0 : sat_sample(fb_wide);

    // crossfade
    assign dry_gain = (GAIN_W + 1)'(MIX_ONE) - {1'b0, i_mix};
    assign o_sum    = {r_pm1[SW+17], r_pm1} + {r_pm2[SW+17], r_pm2};
    assign o_wide   = SAT_W'(o_sum >>> Q_SHIFT);
    assign o_result = sat_sample(o_wide);

    // delay memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr || i_clr) begin
            mem[i_waddr] <= wdata;
        end
        if (i_ctl.rd) begin
            r_rd <= mem[i_raddr];
        end
    end

    // arithmetic stages: tap capture, interpolation, wet sum, feedback and mix products
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_a) begin
            r_a <= r_rd;
        end
        if (i_ctl.interp) begin
            r_dprod <= diff * $signed({1'b0, i_frac});
        end
        if (i_ctl.wet) begin
            r_wet <= wet_sum[SW-1:0];
        end
        if (i_ctl.mul_fb) begin
            r_pfb <= r_wet * $signed({1'b0, i_fb});
        end
        if (i_ctl.wr) begin
            r_pm1 <= i_dry * $signed({1'b0, dry_gain});
        end
        if (i_ctl.mul_mix) begin
            r_pm2 <= r_wet * $signed({2'b00, i_mix});
        end
    end

endmodule

>>> src/sfd_back.sv
// back end: sequencer, memory clearing, two channel lanes and output register
module sfd_back import sfd_pkg::*; #(
    parameter int ADDR_BITS = 17,
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  t_queue_item                    i_q_item,
    output logic                           o_q_pop,
    output logic                           o_clearing,
    output logic                           o_advance,
    input  logic [ADDR_BITS+FRAC_BITS-1:0] i_delay,
    input  logic [GAIN_W-1:0]              i_feedback,
    input  logic [GAIN_W-1:0]              i_mix,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output t_out_item                      o_out
);

    localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDA   = 9'b000000010,
        S_RDB   = 9'b000000100,
        S_INT   = 9'b000001000,
        S_WET   = 9'b000010000,
        S_MFB   = 9'b000100000,
        S_WR    = 9'b001000000,
        S_MMX   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic                   r_clearing;
    logic [ADDR_BITS-1:0]   r_clr_addr;
    logic [ADDR_BITS-1:0]   r_wp;
    logic                   r_stereo;
    logic signed [SAMPLE_BITS-1:0] r_dry_l;
    logic signed [SAMPLE_BITS-1:0] r_dry_r;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   out_free;
    logic                   load_byp;
    logic                   load_echo;
    logic                   start_echo;
    logic [ADDR_BITS-1:0]   tap_n;
    logic [FW-1:0]          frac;
    logic [ADDR_BITS-1:0]   raddr;
    logic [ADDR_BITS-1:0]   waddr;
    t_lane_ctl              ctl;
    logic signed [SAMPLE_BITS-1:0] res_l;
    logic signed [SAMPLE_BITS-1:0] res_r;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_byp   = (r_state == S_IDLE) && !r_clearing && i_q_valid
                        && i_q_item.bypass && out_free;
    assign start_echo = (r_state == S_IDLE) && !r_clearing && i_q_valid
                        && !i_q_item.bypass;
    assign load_echo  = (r_state == S_OUT) && out_free;
    assign o_q_pop    = load_byp || start_echo;
    assign o_advance  = start_echo;
    assign o_clearing = r_clearing;

    // tap addresses from the smoothed delay
    assign tap_n = ADDR_BITS'(i_delay >> FRAC_BITS);
    assign frac  = (FRAC_BITS == 0) ? '0 : i_delay[FW-1:0];
    assign raddr = (r_state == S_RDA) ? r_wp - tap_n - ADDR_BITS'(1)
                                      : r_wp - tap_n - ADDR_BITS'(2);
    assign waddr = r_clearing ? r_clr_addr : r_wp;

    // lane strobes
    always_comb begin
        ctl         = '0;
        ctl.rd      = (r_state == S_RDA) || (r_state == S_RDB);
        ctl.cap_a   = (r_state == S_RDB);
        ctl.interp  = (r_state == S_INT);
        ctl.wet     = (r_state == S_WET);
        ctl.mul_fb  = (r_state == S_MFB);
        ctl.wr      = (r_state == S_WR);
        ctl.mul_mix = (r_state == S_MMX);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start_echo) n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_INT;
            S_INT:   n_state = S_WET;
            S_WET:   n_state = S_MFB;
            S_MFB:   n_state = S_WR;
            S_WR:    n_state = S_MMX;
            S_MMX:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (r_state == S_WR) begin
                r_wp <= r_wp + ADDR_BITS'(1);
            end
            if (load_byp || load_echo) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (start_echo) begin
            r_stereo <= i_q_item.stereo;
            r_dry_l  <= i_q_item.dry_left;
            r_dry_r  <= i_q_item.dry_right;
        end
        if (load_byp) begin
            r_out.out_left  <= i_q_item.dry_left;
            r_out.out_right <= i_q_item.dry_right;
        end else if (load_echo) begin
            r_out.out_left  <= res_l;
            r_out.out_right <= r_stereo ? res_r : '0;
        end
    end

    sfd_lane #(.ADDR_BITS(ADDR_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_l (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_clr    (r_clearing),
        .i_raddr  (raddr),
        .i_waddr  (waddr),
        .i_dry    (r_dry_l),
        .i_frac   (frac),
        .i_fb     (i_feedback),
        .i_mix    (i_mix),
        .o_result (res_l)
    );

    sfd_lane #(.ADDR_BITS(ADDR_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_r (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_clr    (r_clearing),
        .i_raddr  (raddr),
        .i_waddr  (waddr),
        .i_dry    (r_dry_r),
        .i_frac   (frac),
        .i_fb     (i_feedback),
        .i_mix    (i_mix),
        .o_result (res_r)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (r_state == S_IDLE) && !r_out_valid)
        else $error("work started during memory clear");
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=> r_wp == $past(r_wp) + ADDR_BITS'(1))
        else $error("write position did not advance");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && !out_free |=> r_state == S_OUT)
        else $error("result left before output register was free");

endmodule

>>> tb/tb.sv
// testbench for the stereo feedback delay: bypass, echo, ramps and back-pressure
`timescale 1ns / 1ps

module tb;
    import sfd_pkg::*;

    localparam int ADDR_W     = 17;
    localparam int FRAC_W     = 8;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int DELAY_W    = ADDR_W + FRAC_W;
    localparam int IDLE_PCT   = 23;
    localparam int SETTLE     = 24;
    localparam int CYCLE_LIMIT = 3000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stereo_feedback_delay #(.ADDR_BITS(ADDR_W), .FRAC_BITS(FRAC_W)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // echo model state
    int        echo_mem [2][DEPTH];
    bit [ADDR_W-1:0] wr_pos;
    longint    cur_val [3];
    longint    ramp_goal [3];
    longint    ramp_inc [3];
    int        ramp_left [3];
    bit        echo_on;
    bit [3:0]  ramp_pow;

    t_out_item expected_out [$];
    int        fail_count;
    int        cycle_count = 0;
    bit        idle_in_on;
    bit        idle_out_on;
    bit        hold_on;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // receiver stall: long hold when requested, else random idling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_on) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_out_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // result check on each output transfer
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_out.size() == 0) begin
                $error("unexpected result %h", out_item);
                fail_count++;
            end else begin
                want = expected_out.pop_front();
                if (out_item.out_left !== want.out_left) begin
                    $error("out_left expected %0d actual %0d", want.out_left, out_item.out_left);
                    fail_count++;
                end
                if (out_item.out_right !== want.out_right) begin
                    $error("out_right expected %0d actual %0d",
                           want.out_right, out_item.out_right);
                    fail_count++;
                end
            end
        end
    end

    function automatic longint clamp24(longint v);
        longint hi;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic void start_ramp(int k, longint goal);
        longint diff;
        if (goal == ramp_goal[k]) return;
        diff         = goal - cur_val[k];
        ramp_goal[k] = goal;
        ramp_left[k] = 1 << ramp_pow;
        ramp_inc[k]  = (diff >= 0) ? (diff >>> ramp_pow) : -((-diff) >>> ramp_pow);
    endfunction

    function automatic void advance_ramp(int k);
        if (ramp_left[k] == 0) begin
            cur_val[k] = ramp_goal[k];
        end else begin
            ramp_left[k]--;
            if (ramp_left[k] == 0) cur_val[k] = ramp_goal[k];
            else cur_val[k] += ramp_inc[k];
        end
    endfunction

    // one lane: interpolated tap, feedback write, dry/wet crossfade
    function automatic longint echo_lane(int lane, longint dry, int n, int f);
        longint a, b, wet;
        a   = echo_mem[lane][(wr_pos - 1 - n) & (DEPTH - 1)];
        b   = echo_mem[lane][(wr_pos - 2 - n) & (DEPTH - 1)];
        wet = a + (((b - a) * f) >>> FRAC_W);
        echo_mem[lane][wr_pos] = int'(clamp24(dry + ((wet * cur_val[1]) >>> Q_SHIFT)));
        return clamp24((dry * (32768 - cur_val[2]) + wet * cur_val[2]) >>> Q_SHIFT);
    endfunction

    function automatic t_out_item predict_echo(t_in_item it);
        t_out_item r;
        longint dl, dr, ol, orr;
        int d;
        dl = it.sample_left;
        dr = it.sample_right;
        r  = '0;
        if (!echo_on) begin
            r.out_left  = it.sample_left;
            r.out_right = it.right_present ? it.sample_right : '0;
            return r;
        end
        for (int k = 0; k < 3; k++) advance_ramp(k);
        d = int'(cur_val[0]) & ((1 << DELAY_W) - 1);
        if (!it.right_present) dr = dl;
        ol  = echo_lane(0, dl, (d >> FRAC_W) & (DEPTH - 1), d & ((1 << FRAC_W) - 1));
        orr = echo_lane(1, dr, (d >> FRAC_W) & (DEPTH - 1), d & ((1 << FRAC_W) - 1));
        wr_pos++;
        r.out_left  = ol[SAMPLE_BITS-1:0];
        r.out_right = it.right_present ? orr[SAMPLE_BITS-1:0] : '0;
        return r;
    endfunction

    // offer one item, wait for its transfer, record the expected result
    task automatic send_item(t_in_item it);
        while (idle_in_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        expected_out.push_back(predict_echo(it));
    endtask

    task automatic send_samples(int l, int r, bit stereo);
        t_in_item it;
        it.sample_left   = l[SAMPLE_BITS-1:0];
        it.sample_right  = r[SAMPLE_BITS-1:0];
        it.right_present = stereo;
        send_item(it);
    endtask

    // input quiet, all results back, then settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver hold for a number of cycles
    task automatic hold_receiver(int cycles);
        hold_on = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_on = 1'b0;
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        longint v;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ENABLE: echo_on = data[0];
            REG_DELAY: start_ramp(0, longint'(data[DELAY_W-1:0]));
            REG_FEEDBACK: begin
                v = data[FB_FIELD_W-1:0];
                start_ramp(1, (v > FB_MAX) ? longint'(FB_MAX) : v);
            end
            REG_MIX: begin
                v = data[GAIN_W-1:0];
                start_ramp(2, (v > MIX_ONE) ? longint'(MIX_ONE) : v);
            end
            REG_SHIFT: ramp_pow = data[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return 8388607;
            1: return -8388608;
            2: return $urandom_range(0, 255) - 128;
            default: return int'($urandom);
        endcase
    endfunction

    // disabled block passes samples through, mono zeroes the right side
    task automatic test_bypass();
        write_reg(REG_ENABLE, 0);
        send_samples(8388607, -8388608, 1'b1);
        send_samples(-8388608, 8388607, 1'b1);
        send_samples(12345, 777, 1'b0);
        send_samples(0, -1, 1'b1);
        wait_drained();
    endtask

    // instant ramps, clamped gains, saturation, mono feed, wrapped delay
    task automatic test_echo_directed();
        write_reg(REG_SHIFT, 0);
        write_reg(REG_DELAY, 32'h180);
        write_reg(REG_FEEDBACK, 32'h7FFF);
        write_reg(REG_MIX, 32'hFFFF);
        write_reg(REG_ENABLE, 1);
        for (int i = 0; i < 6; i++) send_samples(8388607, -8388608, 1'b1);
        send_samples(-8388608, 8388607, 1'b0);
        send_samples(100, 200, 1'b0);
        wait_drained();
        write_reg(REG_MIX, 0);
        write_reg(REG_DELAY, 32'hFFFF_FFFF);
        write_reg(REG_SHIFT, 15);
        write_reg(REG_FEEDBACK, 0);
        for (int i = 0; i < 5; i++) send_samples(rand_sample(), rand_sample(), 1'b1);
        wait_drained();
    endtask

    // random settings per phase, smoothed parameter ramps in flight
    task automatic test_random_phases();
        for (int p = 0; p < 9; p++) begin
            idle_in_on  = (p != 3);
            idle_out_on = (p != 3);
            write_reg(REG_SHIFT, ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 6));
            write_reg(REG_DELAY, ($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(0, 40 * 256));
            write_reg(REG_FEEDBACK, $urandom);
            write_reg(REG_MIX, ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(0, 65535));
            write_reg(REG_ENABLE, $urandom_range(0, 7) != 0);
            for (int i = 0; i < 100; i++)
                send_samples(rand_sample(), rand_sample(), $urandom_range(0, 3) != 0);
            wait_drained();
        end
        idle_in_on  = 1'b1;
        idle_out_on = 1'b1;
    endtask

    // receiver holds off while items keep coming, then sender pauses
    task automatic test_backpressure();
        write_reg(REG_DELAY, 3 * 256 + 17);
        write_reg(REG_ENABLE, 1);
        fork
            hold_receiver(300);
        join_none
        for (int i = 0; i < 30; i++) send_samples(rand_sample(), rand_sample(), 1'b1);
        wait_drained();
        for (int i = 0; i < 30; i++) send_samples(rand_sample(), rand_sample(), 1'b0);
        wait_drained();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        in_valid    <= 1'b0;
        in_item     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        fail_count  = 0;
        hold_on     = 1'b0;
        idle_in_on  = 1'b1;
        idle_out_on = 1'b1;
        wr_pos      = '0;
        echo_on     = 1'b0;
        ramp_pow    = SHIFT_RESET;
        for (int k = 0; k < 3; k++) begin
            cur_val[k]   = 0;
            ramp_goal[k] = 0;
            ramp_inc[k]  = 0;
            ramp_left[k] = 0;
        end
        for (int i = 0; i < DEPTH; i++) begin
            echo_mem[0][i] = 0;
            echo_mem[1][i] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bypass();
        test_echo_directed();
        test_random_phases();
        test_backpressure();

        wait_drained();
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
